// ===== rtl/vqc_pkg.sv =====
package vqc_pkg;

    // Input kinds (s-side tuser)
    localparam logic [1:0] KIND_TRAIN  = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_DECODE = 2'd2;

    // Result status (m-side tuser)
    localparam logic [1:0] STAT_NEW  = 2'd0;
    localparam logic [1:0] STAT_HIT  = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;

    localparam int PIX_W  = 8;
    localparam int WORD_W = 4 * PIX_W;
    localparam int CODE_W = 6;
    localparam int DIST_W = 18;   // 4 * 255^2 fits

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DEC_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear;   // drop the running best, new search begins
        logic issue;   // a codebook read is issued this cycle
    } t_scan_ctl;

endpackage

// ===== rtl/vqc_ram.sv =====
module vqc_ram import vqc_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vqc_nearest.sv =====
module vqc_nearest import vqc_pkg::*; #(
    parameter int IW = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_scan_ctl         i_ctl,
    input  logic [IW-1:0]     i_idx,
    input  logic [WORD_W-1:0] i_pix,
    input  logic [WORD_W-1:0] i_rdata,
    output logic              o_busy,
    output logic [IW-1:0]     o_best_idx,
    output logic [WORD_W-1:0] o_best_word
);

    // stage 1: read data back from RAM; stage 2: squares; then sum + compare
    logic              r_v1, r_v2, r_have;
    logic [IW-1:0]     r_idx1, r_idx2, r_best_idx;
    logic [WORD_W-1:0] r_word2, r_best_word;
    logic [15:0]       r_sq [4];
    logic [DIST_W-1:0] r_best_dist;
    logic [15:0]       w_sq [4];
    logic [DIST_W-1:0] w_dist;

    always_comb begin
        logic [PIX_W-1:0] a, b, d;
        for (int k = 0; k < 4; k++) begin
            a = i_pix[k*PIX_W +: PIX_W];
            b = i_rdata[k*PIX_W +: PIX_W];
            d = (a > b) ? (a - b) : (b - a);
            w_sq[k] = {8'd0, d} * {8'd0, d};
        end
    end

    assign w_dist = {2'd0, r_sq[0]} + {2'd0, r_sq[1]} + {2'd0, r_sq[2]} + {2'd0, r_sq[3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_have <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            if (i_ctl.clear) begin
                r_have <= 1'b0;
            end else if (r_v2 && (!r_have || w_dist < r_best_dist)) begin
                r_have <= 1'b1;
            end
        end
        r_idx1  <= i_idx;
        r_idx2  <= r_idx1;
        r_word2 <= i_rdata;
        for (int k = 0; k < 4; k++) begin
            r_sq[k] <= w_sq[k];
        end
        // strict less-than over ascending index keeps the lowest on ties
        if (r_v2 && (!r_have || w_dist < r_best_dist) && !i_ctl.clear) begin
            r_best_dist <= w_dist;
            r_best_idx  <= r_idx2;
            r_best_word <= r_word2;
        end
    end

    assign o_busy      = r_v1 | r_v2;
    assign o_best_idx  = r_best_idx;
    assign o_best_word = r_best_word;

endmodule

// ===== rtl/vq_codebook_train_encode.sv =====
// 2x2 gray-block vector quantizer with an on-chip codebook of CODEWORDS entries.
// Slave channel: one word per item, tuser = kind (train, encode, decode),
//   tdata = four pixels and a code index for decode.
// Master channel: one word per item, tuser = status, tdata = index and the
//   codeword pixels (after the averaging update, for a train item).
// Train fills empty entries in order; once full it averages the block into the
// nearest entry. Encode returns the nearest filled entry. Decode reads one entry.
// Search: every filled entry streams out of the single-port-read RAM, one per
//   cycle, then the search pipeline drains and the result is handed off; the
//   next word is taken only once the block is back in idle. Fill, decode and
//   error items do not search. One item is processed at a time; the RAM read
//   port sets the rate.
// The output register lets the next item be accepted while a result is still
//   waiting; a stalled receiver holds the finished result in that register and
//   a further result waits until it drains.
// Reset (synchronous, active low) empties the codebook by clearing the fill
//   count; RAM contents are not cleared and are never used before written.
module vq_codebook_train_encode import vqc_pkg::*; #(
    parameter int CODEWORDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // pixel0, pixel1, pixel2, pixel3, code_in, pad
    input  logic [1:0]  i_s_axis_tuser,   // kind
    // m side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // code_index, word0, word1, word2, word3, pad
    output logic [1:0]  o_m_axis_tuser    // status
);

    localparam int IW = (CODEWORDS > 1) ? $clog2(CODEWORDS) : 1;
    localparam int CW = $clog2(CODEWORDS + 1);

    t_state r_state, n_state;

    // captured item
    logic [1:0]        r_kind;
    logic [WORD_W-1:0] r_pix;

    logic [CW-1:0]     r_filled;
    logic [CW-1:0]     r_scan_cnt;

    // result waiting for the output register
    logic [CODE_W-1:0] r_res_idx;
    logic [WORD_W-1:0] r_res_word;
    logic [1:0]        r_res_stat;

    // output register
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_idx;
    logic [WORD_W-1:0] r_out_word;
    logic [1:0]        r_out_stat;

    // RAM and search unit
    logic              w_we;
    logic [IW-1:0]     w_waddr, w_raddr;
    logic [WORD_W-1:0] w_wdata, w_rdata;
    t_scan_ctl         w_ctl;
    logic              w_busy;
    logic [IW-1:0]     w_best_idx;
    logic [WORD_W-1:0] w_best_word;

    // decode of the incoming word
    logic              w_accept;
    logic [1:0]        w_kind;
    logic [WORD_W-1:0] w_pix;
    logic [CODE_W-1:0] w_code;
    logic              w_full, w_empty, w_dec_hit, w_scan_last, w_out_free;
    logic [CW+5:0]     w_code_cmp, w_fill_cmp;
    logic [IW+5:0]     w_code_ext, w_fill_ext, w_best_ext;
    logic [WORD_W-1:0] w_avg;

    assign w_accept = i_s_axis_tvalid & o_s_axis_tready;
    assign w_kind   = i_s_axis_tuser;
    assign w_pix    = i_s_axis_tdata[WORD_W-1:0];
    assign w_code   = i_s_axis_tdata[WORD_W +: CODE_W];

    assign w_full  = (r_filled == CW'(CODEWORDS));
    assign w_empty = (r_filled == '0);

    // code < filled also implies code < CODEWORDS
    assign w_code_cmp = {{CW{1'b0}}, w_code};
    assign w_fill_cmp = {6'd0, r_filled};
    assign w_dec_hit  = (w_code_cmp < w_fill_cmp);

    assign w_code_ext = {{IW{1'b0}}, w_code};
    assign w_fill_ext = {6'd0, r_filled[IW-1:0]};
    assign w_best_ext = {6'd0, w_best_idx};

    assign w_scan_last = (r_scan_cnt == r_filled - CW'(1));
    assign w_out_free  = !r_out_valid || i_m_axis_tready;

    // floor of the pixel-wise mean of the chosen entry and the block
    always_comb begin
        logic [PIX_W:0] s;
        for (int k = 0; k < 4; k++) begin
            s = {1'b0, w_best_word[k*PIX_W +: PIX_W]} + {1'b0, r_pix[k*PIX_W +: PIX_W]};
            w_avg[k*PIX_W +: PIX_W] = s[PIX_W:1];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_kind)
                        KIND_TRAIN:  n_state = w_full ? ST_SCAN : ST_DONE;
                        KIND_ENCODE: n_state = w_empty ? ST_DONE : ST_SCAN;
                        KIND_DECODE: n_state = w_dec_hit ? ST_DEC_DATA : ST_DONE;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:     if (w_scan_last) n_state = ST_DRAIN;
            ST_DRAIN:    if (!w_busy) n_state = ST_DONE;
            ST_DEC_DATA: n_state = ST_DONE;
            ST_DONE:     if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_we            = 1'b0;
        w_waddr         = r_filled[IW-1:0];
        w_wdata         = w_pix;
        w_raddr         = r_scan_cnt[IW-1:0];
        w_ctl.clear     = 1'b0;
        w_ctl.issue     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // no word is taken while reset is held
                o_s_axis_tready = i_rst_n;
                w_raddr         = w_code_ext[IW-1:0];
                w_ctl.clear     = i_s_axis_tvalid;
                w_we            = w_accept && (w_kind == KIND_TRAIN) && !w_full;
            end
            ST_SCAN: begin
                w_ctl.issue = 1'b1;
            end
            ST_DRAIN: begin
                w_waddr = w_best_idx;
                w_wdata = w_avg;
                w_we    = !w_busy && (r_kind == KIND_TRAIN);
            end
            ST_DEC_DATA, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (w_kind == KIND_TRAIN) && !w_full) begin
                r_filled <= r_filled + CW'(1);
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind     <= w_kind;
            r_pix      <= w_pix;
            r_scan_cnt <= '0;
            case (w_kind)
                KIND_TRAIN: begin
                    if (!w_full) begin
                        r_res_idx  <= w_fill_ext[CODE_W-1:0];
                        r_res_word <= w_pix;
                        r_res_stat <= STAT_NEW;
                    end else begin
                        r_res_idx  <= '0;
                        r_res_word <= '0;
                        r_res_stat <= STAT_MISS;
                    end
                end
                KIND_DECODE: begin
                    r_res_idx  <= w_code;
                    r_res_word <= '0;
                    r_res_stat <= STAT_MISS;
                end
                default: begin
                    r_res_idx  <= '0;
                    r_res_word <= '0;
                    r_res_stat <= STAT_MISS;
                end
            endcase
        end
        if (r_state == ST_SCAN) begin
            r_scan_cnt <= r_scan_cnt + CW'(1);
        end
        if (r_state == ST_DRAIN && !w_busy) begin
            r_res_idx  <= w_best_ext[CODE_W-1:0];
            r_res_word <= (r_kind == KIND_TRAIN) ? w_avg : w_best_word;
            r_res_stat <= STAT_HIT;
        end
        if (r_state == ST_DEC_DATA) begin
            r_res_word <= w_rdata;
            r_res_stat <= STAT_HIT;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_idx  <= r_res_idx;
            r_out_word <= r_res_word;
            r_out_stat <= r_res_stat;
        end
    end

    vqc_ram #(
        .DEPTH (CODEWORDS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    vqc_nearest #(
        .IW (IW)
    ) u_nearest (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_idx       (r_scan_cnt[IW-1:0]),
        .i_pix       (r_pix),
        .i_rdata     (w_rdata),
        .o_busy      (w_busy),
        .o_best_idx  (w_best_idx),
        .o_best_word (w_best_word)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'd0, r_out_word, r_out_idx};
    assign o_m_axis_tuser  = r_out_stat;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vqc_pkg::*;

    // Kind code outside the three defined kinds: the block must answer it
    // with a miss and leave the codebook alone.
    localparam logic [1:0] KIND_BAD = 2'd3;

    localparam int BOOK_SIZE   = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 100;         // longer than a full-codebook search
    localparam int RANDOM_ITEMS = 1200;

    // One input word: kind goes on tuser, the rest packed into tdata.
    typedef struct packed {
        logic [1:0]      kind;
        logic [3:0][7:0] px;      // px[0] = top-left ... px[3] = bottom-right
        logic [5:0]      code;
    } t_item;

    // One result word: status on tuser, index and codeword pixels in tdata.
    typedef struct packed {
        logic [5:0]      idx;
        logic [3:0][7:0] word;
        logic [1:0]      status;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;    // pixel0, pixel1, pixel2, pixel3, code_in, pad
    logic [1:0]  i_s_axis_tuser;    // kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;    // code_index, word0, word1, word2, word3, pad
    logic [1:0]  o_m_axis_tuser;    // status

    vq_codebook_train_encode #(.CODEWORDS(BOOK_SIZE)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the codebook and its fill level.
    // Entries at or above book_fill are never looked at.
    // ------------------------------------------------------------------
    logic [3:0][7:0] book [BOOK_SIZE];
    int unsigned     book_fill;

    t_result pending_results [$];   // predicted words not yet seen on m side
    bit      mismatch_seen;
    bit      idle_en;               // 0 = both sides run back to back
    int unsigned cycle_count;

    // Smallest sum of squared differences over the filled entries;
    // strict less-than keeps the lowest index on a tie.
    function automatic int unsigned nearest_code(input logic [3:0][7:0] px);
        int unsigned best;
        int unsigned best_dist;
        int unsigned sq_sum;
        int          d;
        best      = 0;
        best_dist = 0;
        for (int n = 0; n < book_fill; n++) begin
            sq_sum = 0;
            for (int k = 0; k < 4; k++) begin
                d = int'(px[k]) - int'(book[n][k]);
                sq_sum += d * d;
            end
            if (n == 0 || sq_sum < best_dist) begin
                best_dist = sq_sum;
                best      = n;
            end
        end
        return best;
    endfunction

    // Expected result of one accepted item; updates the codebook copy.
    function automatic t_result quantize_item(input t_item it);
        t_result     r;
        int unsigned idx;
        logic [8:0]  sum;
        r = '0;
        case (it.kind)
            KIND_TRAIN: begin
                if (book_fill < BOOK_SIZE) begin
                    // still filling: next empty slot takes the block as is
                    idx       = book_fill;
                    book[idx] = it.px;
                    book_fill = book_fill + 1;
                    r.status  = STAT_NEW;
                end else begin
                    // full: pull the nearest entry halfway toward the block
                    idx = nearest_code(it.px);
                    for (int k = 0; k < 4; k++) begin
                        sum         = {1'b0, book[idx][k]} + {1'b0, it.px[k]};
                        book[idx][k] = sum[8:1];
                    end
                    r.status = STAT_HIT;
                end
                r.idx  = idx[5:0];
                r.word = book[idx];
            end
            KIND_ENCODE: begin
                if (book_fill == 0) begin
                    r.status = STAT_MISS;
                end else begin
                    idx      = nearest_code(it.px);
                    r.idx    = idx[5:0];
                    r.word   = book[idx];
                    r.status = STAT_HIT;
                end
            end
            KIND_DECODE: begin
                r.idx = it.code;
                if (it.code < book_fill) begin
                    r.word   = book[it.code];
                    r.status = STAT_HIT;
                end else begin
                    r.status = STAT_MISS;
                end
            end
            default: r.status = STAT_MISS;
        endcase
        return r;
    endfunction

    // Gap/stall lengths: mostly short, now and then long.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(1, 2);
        else if (sel < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // Random 2x2 block: uniform, clustered, saturated, or a copy of an
    // existing codeword (exact hits and ties) with an occasional nudge.
    function automatic logic [3:0][7:0] random_block();
        logic [3:0][7:0] b;
        int sel;
        int base;
        int v;
        sel = $urandom_range(0, 9);
        b   = $urandom();
        if (sel >= 4 && sel < 6) begin
            base = $urandom_range(0, 255);
            for (int k = 0; k < 4; k++) begin
                v    = base + $urandom_range(0, 16) - 8;
                b[k] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
            end
        end else if (sel == 6) begin
            for (int k = 0; k < 4; k++)
                b[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (sel >= 7 && book_fill > 0) begin
            b = book[$urandom_range(0, book_fill - 1)];
            if (sel == 9)
                b[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 2));
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Send one word on the s side. Inputs move only at the falling edge;
    // tvalid stays high into the next call so back-to-back words never
    // see a drop-and-raise in the same step.
    // ------------------------------------------------------------------
    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 99) >= 60)
            gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = it.kind;
        i_s_axis_tdata  = {2'b00, it.code, it.px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(quantize_item(it));
    endtask

    function automatic t_item make_item(input logic [1:0] kind,
                                        input logic [3:0][7:0] px,
                                        input logic [5:0] code);
        t_item it;
        it.kind = kind;
        it.px   = px;
        it.code = code;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // m side: random stalls, none while idle_en is low.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!idle_en) begin
                i_m_axis_tready = 1'b1;
                stall = 0;
            end else if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                stall--;
            end else begin
                i_m_axis_tready = 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall = pick_gap();
            end
        end
    end

    // Result checker: compare every accepted m-side word with the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.idx    = o_m_axis_tdata[5:0];
            got.word   = o_m_axis_tdata[37:6];
            got.status = o_m_axis_tuser;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: code_index %0d status %0d",
                       got.idx, got.status);
                mismatch_seen = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (got.idx !== want.idx) begin
                    $error("code_index: expected %0d, got %0d", want.idx, got.idx);
                    mismatch_seen = 1'b1;
                end
                for (int k = 0; k < 4; k++) begin
                    if (got.word[k] !== want.word[k]) begin
                        $error("word%0d: expected %0d, got %0d",
                               k, want.word[k], got.word[k]);
                        mismatch_seen = 1'b1;
                    end
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing trained yet: encode and decode both miss, bad kind misses.
    task automatic test_empty_book();
        send_item(make_item(KIND_ENCODE, {4{8'hFF}}, 6'd0));
        send_item(make_item(KIND_DECODE, {4{8'h00}}, 6'd0));
        send_item(make_item(KIND_DECODE, {4{8'hFF}}, 6'd63));
        send_item(make_item(KIND_BAD, {4{8'hFF}}, 6'd63));
    endtask

    // First fills: pixel extremes, a duplicate entry, and two entries
    // equally far from a midpoint; then decode filled and empty slots.
    task automatic test_fill_and_decode();
        send_item(make_item(KIND_TRAIN, {4{8'h00}}, 6'd0));                 // slot 0
        send_item(make_item(KIND_TRAIN, {4{8'hFF}}, 6'd63));                // slot 1
        send_item(make_item(KIND_TRAIN, {4{8'h00}}, 6'd0));                 // slot 2 = slot 0
        send_item(make_item(KIND_TRAIN, {4{8'd10}}, 6'd0));                 // slot 3
        send_item(make_item(KIND_TRAIN, {4{8'd30}}, 6'd0));                 // slot 4
        send_item(make_item(KIND_TRAIN, {8'h55, 8'hAA, 8'h55, 8'hAA}, 6'd0)); // slot 5
        send_item(make_item(KIND_DECODE, '0, 6'd1));
        send_item(make_item(KIND_DECODE, '0, 6'd5));
        send_item(make_item(KIND_DECODE, '0, 6'd6));       // first empty slot
        send_item(make_item(KIND_DECODE, '0, 6'd42));      // 101010, empty
        send_item(make_item(KIND_DECODE, '0, 6'd21));      // 010101, empty
    endtask

    // Nearest search, ties to the lowest index, bad kind after filling.
    task automatic test_nearest_and_ties();
        send_item(make_item(KIND_ENCODE, {4{8'h00}}, 6'd0));   // slots 0 and 2 tie
        send_item(make_item(KIND_ENCODE, {4{8'd20}}, 6'd0));   // slots 3 and 4 tie
        send_item(make_item(KIND_ENCODE, {4{8'hFF}}, 6'd0));
        send_item(make_item(KIND_ENCODE, {8'h54, 8'hAB, 8'h56, 8'hA9}, 6'd0));
        send_item(make_item(KIND_BAD, {4{8'h00}}, 6'd0));
        send_item(make_item(KIND_DECODE, '0, 6'd2));
    endtask

    // Random mix: the rest of the fill, the first averaging train, then
    // steady traffic on a full codebook. Some stretches run with no gaps.
    task automatic test_random_traffic(input int count);
        t_item it;
        int    sel;
        for (int i = 0; i < count; i++) begin
            idle_en = ((i % 150) >= 30);
            sel     = $urandom_range(0, 99);
            it.px   = random_block();
            it.code = $urandom_range(0, 63);
            if (sel < 40)
                it.kind = KIND_TRAIN;
            else if (sel < 75)
                it.kind = KIND_ENCODE;
            else if (sel < 95)
                it.kind = KIND_DECODE;
            else
                it.kind = KIND_BAD;
            send_item(it);
        end
        idle_en = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = KIND_TRAIN;
        i_m_axis_tready = 1'b0;
        book_fill       = 0;
        mismatch_seen   = 1'b0;
        idle_en         = 1'b1;
        cycle_count     = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_book();
        test_fill_and_decode();
        test_nearest_and_ties();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        // let every predicted word arrive, then watch for strays
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (!mismatch_seen && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
